FILE: sv/lbp_pkg.sv
package lbp_pkg;

    localparam int IMAGE_DIM     = 512;
    localparam int MAX_BEAMS     = 4096;
    localparam int HALF_IMG      = IMAGE_DIM / 2;
    localparam int RANGE_OFFSET  = 256;
    localparam int CORDIC_STAGES = 14;
    localparam int CORDIC_X0     = 9949;
    localparam int Q14_ONE       = 16384;

    localparam int IDX_W   = 12;
    localparam int RANGE_W = 20;
    localparam int ANGLE_W = 16;
    localparam int SCALE_W = 16;
    localparam int PIX_W   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Signed range after the offset is taken off, and CORDIC datapath width.
    localparam int R_W   = RANGE_W + 1;
    localparam int CRD_W = 18;
    localparam int CS_W  = 16;
    localparam int PRD1_W = R_W + CS_W;
    localparam int PRD2_W = PRD1_W + SCALE_W + 1;
    localparam int TRUNC_W = PRD2_W - 32;
    localparam int POS_W   = TRUNC_W + 1;
    localparam int BEAM_CMP_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_PER_M   = 3'd4;

    localparam logic signed [CRD_W-1:0] ATAN_TURN [CORDIC_STAGES] = '{
        18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
        18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
    };

    // Travels with every item down the pipeline.
    typedef struct packed {
        logic                  valid;
        logic                  ok;
        logic signed [R_W-1:0] r;
    } side_t;

endpackage

FILE: sv/lidar_beam_to_pixel_top.sv
// Each accepted beam passes the angle, CORDIC and scale registers before done rises.
// Throughput: one beam per cycle; busy is always low and every cycle may carry a transfer.
// The depth comes from the 14-stage CORDIC plus angle, multiply and truncate stages.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults.
module lidar_beam_to_pixel_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lbp_pkg::IDX_W-1:0]            beam_index,
    input  logic [lbp_pkg::RANGE_W-1:0]          range_sample,
    input  logic                                 wr_en,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]       wr_data,
    output logic                                 done,
    output logic [lbp_pkg::PIX_W-1:0]            pixel_x,
    output logic [lbp_pkg::PIX_W-1:0]            pixel_y,
    output logic                                 hit
);

    localparam int LATENCY = 21;

    logic [lbp_pkg::ANGLE_W-1:0]         angle_start_reg;
    logic [lbp_pkg::ANGLE_W-1:0]         angle_step_reg;
    logic [lbp_pkg::RANGE_W-1:0]         range_floor_reg;
    logic [lbp_pkg::RANGE_W-1:0]         range_limit_reg;
    logic [lbp_pkg::SCALE_W-1:0]         pix_per_m_reg;

    logic                                accept;
    lbp_pkg::side_t                      ang_side;
    logic signed [lbp_pkg::CRD_W-1:0]    ang_z;
    logic                                ang_neg;
    lbp_pkg::side_t                      crd_side;
    logic signed [lbp_pkg::CRD_W-1:0]    crd_x;
    logic signed [lbp_pkg::CRD_W-1:0]    crd_y;
    logic                                crd_neg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= '0;
            angle_step_reg  <= 16'd182;
            range_floor_reg <= '0;
            range_limit_reg <= 20'd3584;
            pix_per_m_reg   <= 16'd18725;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lbp_pkg::REG_ANGLE_START: angle_start_reg <= wr_data[lbp_pkg::ANGLE_W-1:0];
                lbp_pkg::REG_ANGLE_STEP:  angle_step_reg  <= wr_data[lbp_pkg::ANGLE_W-1:0];
                lbp_pkg::REG_RANGE_FLOOR: range_floor_reg <= wr_data[lbp_pkg::RANGE_W-1:0];
                lbp_pkg::REG_RANGE_LIMIT: range_limit_reg <= wr_data[lbp_pkg::RANGE_W-1:0];
                lbp_pkg::REG_PIX_PER_M:   pix_per_m_reg   <= wr_data[lbp_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lbp_angle u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .beam_index   (beam_index),
        .range_sample (range_sample),
        .angle_start  (angle_start_reg),
        .angle_step   (angle_step_reg),
        .range_floor  (range_floor_reg),
        .range_limit  (range_limit_reg),
        .side_out     (ang_side),
        .z_out        (ang_z),
        .neg_out      (ang_neg)
    );

    lbp_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (ang_side),
        .z_in     (ang_z),
        .neg_in   (ang_neg),
        .side_out (crd_side),
        .x_out    (crd_x),
        .y_out    (crd_y),
        .neg_out  (crd_neg)
    );

    lbp_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .side_in          (crd_side),
        .x_in             (crd_x),
        .y_in             (crd_y),
        .neg_in           (crd_neg),
        .pixels_per_meter (pix_per_m_reg),
        .done             (done),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .hit              (hit)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (pixel_x == '0 && pixel_y == '0))
        else $error("miss result carries nonzero coordinates");

    a_hit_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit raised without a result strobe");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted beam did not produce a result on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##LATENCY !done)
        else $error("result strobe without an accepted beam");

endmodule

FILE: sv/lbp_angle.sv
module lbp_angle (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [lbp_pkg::IDX_W-1:0]           beam_index,
    input  logic [lbp_pkg::RANGE_W-1:0]         range_sample,
    input  logic [lbp_pkg::ANGLE_W-1:0]         angle_start,
    input  logic [lbp_pkg::ANGLE_W-1:0]         angle_step,
    input  logic [lbp_pkg::RANGE_W-1:0]         range_floor,
    input  logic [lbp_pkg::RANGE_W-1:0]         range_limit,
    output lbp_pkg::side_t                      side_out,
    output logic signed [lbp_pkg::CRD_W-1:0]    z_out,
    output logic                                neg_out
);

    logic signed [lbp_pkg::R_W:0]         r_wide;
    logic                                 range_ok;
    logic                                 beam_ok;
    logic [lbp_pkg::ANGLE_W-1:0]          angle_next;
    logic [lbp_pkg::ANGLE_W-1:0]          angle_reg;
    lbp_pkg::side_t                       side1_next;
    lbp_pkg::side_t                       side1_reg;
    lbp_pkg::side_t                       side2_reg;
    logic signed [lbp_pkg::CRD_W-1:0]     z_raw;
    logic signed [lbp_pkg::CRD_W-1:0]     z_next;
    logic                                 neg_next;
    logic signed [lbp_pkg::CRD_W-1:0]     z_reg;
    logic                                 neg_reg;

    always_comb
    begin
        r_wide = $signed({2'b00, range_sample}) - (lbp_pkg::R_W + 1)'(lbp_pkg::RANGE_OFFSET);
        range_ok = (r_wide > $signed({2'b00, range_floor}))
                && (r_wide < $signed({2'b00, range_limit}));
        beam_ok = (lbp_pkg::BEAM_CMP_W'(beam_index) < lbp_pkg::BEAM_CMP_W'(lbp_pkg::MAX_BEAMS));
        angle_next = angle_start + lbp_pkg::ANGLE_W'(lbp_pkg::ANGLE_W'(beam_index) * angle_step);
        side1_next.valid = accept;
        side1_next.ok    = range_ok && beam_ok;
        side1_next.r     = r_wide[lbp_pkg::R_W-1:0];
    end

    // Fold the angle into the right half plane; the result is negated later.
    always_comb
    begin
        z_raw = lbp_pkg::CRD_W'($signed(angle_reg));
        priority if (z_raw > lbp_pkg::CRD_W'(lbp_pkg::Q14_ONE))
        begin
            z_next   = z_raw - lbp_pkg::CRD_W'(2 * lbp_pkg::Q14_ONE);
            neg_next = 1'b1;
        end
        else if (z_raw < -lbp_pkg::CRD_W'(lbp_pkg::Q14_ONE))
        begin
            z_next   = z_raw + lbp_pkg::CRD_W'(2 * lbp_pkg::Q14_ONE);
            neg_next = 1'b1;
        end
        else
        begin
            z_next   = z_raw;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
        end
        else
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        z_reg     <= z_next;
        neg_reg   <= neg_next;
    end

    assign side_out = side2_reg;
    assign z_out    = z_reg;
    assign neg_out  = neg_reg;

endmodule

FILE: sv/lbp_cordic.sv
module lbp_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbp_pkg::side_t                      side_in,
    input  logic signed [lbp_pkg::CRD_W-1:0]    z_in,
    input  logic                                neg_in,
    output lbp_pkg::side_t                      side_out,
    output logic signed [lbp_pkg::CRD_W-1:0]    x_out,
    output logic signed [lbp_pkg::CRD_W-1:0]    y_out,
    output logic                                neg_out
);

    lbp_pkg::side_t                      side_reg [lbp_pkg::CORDIC_STAGES];
    logic signed [lbp_pkg::CRD_W-1:0]    x_reg    [lbp_pkg::CORDIC_STAGES];
    logic signed [lbp_pkg::CRD_W-1:0]    y_reg    [lbp_pkg::CORDIC_STAGES];
    logic signed [lbp_pkg::CRD_W-1:0]    z_reg    [lbp_pkg::CORDIC_STAGES];
    logic                                neg_reg  [lbp_pkg::CORDIC_STAGES];

    genvar i;
    generate
        for (i = 0; i < lbp_pkg::CORDIC_STAGES; i++)
        begin : g_stage
            lbp_pkg::side_t                      side_cur;
            logic signed [lbp_pkg::CRD_W-1:0]    x_cur;
            logic signed [lbp_pkg::CRD_W-1:0]    y_cur;
            logic signed [lbp_pkg::CRD_W-1:0]    z_cur;
            logic                                neg_cur;
            logic signed [lbp_pkg::CRD_W-1:0]    x_next;
            logic signed [lbp_pkg::CRD_W-1:0]    y_next;
            logic signed [lbp_pkg::CRD_W-1:0]    z_next;

            if (i == 0)
            begin : g_first
                assign side_cur = side_in;
                assign x_cur    = lbp_pkg::CRD_W'(lbp_pkg::CORDIC_X0);
                assign y_cur    = '0;
                assign z_cur    = z_in;
                assign neg_cur  = neg_in;
            end
            else
            begin : g_rest
                assign side_cur = side_reg[i-1];
                assign x_cur    = x_reg[i-1];
                assign y_cur    = y_reg[i-1];
                assign z_cur    = z_reg[i-1];
                assign neg_cur  = neg_reg[i-1];
            end

            // Arithmetic shifts round toward minus infinity.
            always_comb
            begin
                if (z_cur >= 0)
                begin
                    x_next = x_cur - (y_cur >>> i);
                    y_next = y_cur + (x_cur >>> i);
                    z_next = z_cur - lbp_pkg::ATAN_TURN[i];
                end
                else
                begin
                    x_next = x_cur + (y_cur >>> i);
                    y_next = y_cur - (x_cur >>> i);
                    z_next = z_cur + lbp_pkg::ATAN_TURN[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[i] <= '0;
                end
                else
                begin
                    side_reg[i] <= side_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                z_reg[i]   <= z_next;
                neg_reg[i] <= neg_cur;
            end
        end
    endgenerate

    assign side_out = side_reg[lbp_pkg::CORDIC_STAGES-1];
    assign x_out    = x_reg[lbp_pkg::CORDIC_STAGES-1];
    assign y_out    = y_reg[lbp_pkg::CORDIC_STAGES-1];
    assign neg_out  = neg_reg[lbp_pkg::CORDIC_STAGES-1];

endmodule

FILE: sv/lbp_scale.sv
module lbp_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbp_pkg::side_t                      side_in,
    input  logic signed [lbp_pkg::CRD_W-1:0]    x_in,
    input  logic signed [lbp_pkg::CRD_W-1:0]    y_in,
    input  logic                                neg_in,
    input  logic [lbp_pkg::SCALE_W-1:0]         pixels_per_meter,
    output logic                                done,
    output logic [lbp_pkg::PIX_W-1:0]           pixel_x,
    output logic [lbp_pkg::PIX_W-1:0]           pixel_y,
    output logic                                hit
);

    localparam logic signed [lbp_pkg::CRD_W-1:0] ONE_Q14 = lbp_pkg::CRD_W'(lbp_pkg::Q14_ONE);
    localparam logic signed [lbp_pkg::PRD2_W-1:0] TRUNC_BIAS =
        {{(lbp_pkg::PRD2_W-32){1'b0}}, 32'hFFFF_FFFF};

    lbp_pkg::side_t                         side_a_reg;
    lbp_pkg::side_t                         side_b_reg;
    lbp_pkg::side_t                         side_c_reg;
    lbp_pkg::side_t                         side_d_reg;

    logic signed [lbp_pkg::CRD_W-1:0]       xs;
    logic signed [lbp_pkg::CRD_W-1:0]       ys;
    logic signed [lbp_pkg::CS_W-1:0]        cos_next;
    logic signed [lbp_pkg::CS_W-1:0]        sin_next;
    logic signed [lbp_pkg::CS_W-1:0]        cos_reg;
    logic signed [lbp_pkg::CS_W-1:0]        sin_reg;

    logic signed [lbp_pkg::PRD1_W-1:0]      rc_reg;
    logic signed [lbp_pkg::PRD1_W-1:0]      rs_reg;
    logic signed [lbp_pkg::PRD2_W-1:0]      px_prod_reg;
    logic signed [lbp_pkg::PRD2_W-1:0]      py_prod_reg;
    logic signed [lbp_pkg::PRD2_W-1:0]      px_adj;
    logic signed [lbp_pkg::PRD2_W-1:0]      py_adj;
    logic signed [lbp_pkg::TRUNC_W-1:0]     tx_reg;
    logic signed [lbp_pkg::TRUNC_W-1:0]     ty_reg;

    logic signed [lbp_pkg::POS_W-1:0]       pos_x;
    logic signed [lbp_pkg::POS_W-1:0]       pos_y;
    logic                                   in_image;

    logic                                   done_reg;
    logic                                   hit_reg;
    logic [lbp_pkg::PIX_W-1:0]              pixel_x_reg;
    logic [lbp_pkg::PIX_W-1:0]              pixel_y_reg;

    // Undo the half-turn fold and clamp to plus or minus one in Q1.14.
    always_comb
    begin
        xs = neg_in ? -x_in : x_in;
        ys = neg_in ? -y_in : y_in;
        if (xs > ONE_Q14)
        begin
            cos_next = lbp_pkg::CS_W'(lbp_pkg::Q14_ONE);
        end
        else if (xs < -ONE_Q14)
        begin
            cos_next = -lbp_pkg::CS_W'(lbp_pkg::Q14_ONE);
        end
        else
        begin
            cos_next = xs[lbp_pkg::CS_W-1:0];
        end
        if (ys > ONE_Q14)
        begin
            sin_next = lbp_pkg::CS_W'(lbp_pkg::Q14_ONE);
        end
        else if (ys < -ONE_Q14)
        begin
            sin_next = -lbp_pkg::CS_W'(lbp_pkg::Q14_ONE);
        end
        else
        begin
            sin_next = ys[lbp_pkg::CS_W-1:0];
        end
    end

    // Truncation toward zero: bias negative products before the shift.
    always_comb
    begin
        px_adj = px_prod_reg[lbp_pkg::PRD2_W-1] ? px_prod_reg + TRUNC_BIAS : px_prod_reg;
        py_adj = py_prod_reg[lbp_pkg::PRD2_W-1] ? py_prod_reg + TRUNC_BIAS : py_prod_reg;
    end

    always_comb
    begin
        pos_x = lbp_pkg::POS_W'(tx_reg) + lbp_pkg::POS_W'(lbp_pkg::HALF_IMG);
        pos_y = lbp_pkg::POS_W'(ty_reg) + lbp_pkg::POS_W'(lbp_pkg::HALF_IMG);
        in_image = (pos_x >= 0) && (pos_x < lbp_pkg::POS_W'(lbp_pkg::IMAGE_DIM))
                && (pos_y >= 0) && (pos_y < lbp_pkg::POS_W'(lbp_pkg::IMAGE_DIM))
                && side_d_reg.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
            side_d_reg <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
            side_d_reg <= side_c_reg;
            done_reg   <= side_d_reg.valid;
            hit_reg    <= side_d_reg.valid && in_image;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
        rc_reg      <= side_a_reg.r * cos_reg;
        rs_reg      <= side_a_reg.r * sin_reg;
        px_prod_reg <= rc_reg * $signed({1'b0, pixels_per_meter});
        py_prod_reg <= rs_reg * $signed({1'b0, pixels_per_meter});
        tx_reg      <= px_adj[lbp_pkg::PRD2_W-1:32];
        ty_reg      <= py_adj[lbp_pkg::PRD2_W-1:32];
        pixel_x_reg <= in_image ? pos_x[lbp_pkg::PIX_W-1:0] : '0;
        pixel_y_reg <= in_image ? pos_y[lbp_pkg::PIX_W-1:0] : '0;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;

endmodule

FILE: tb/tb_lidar_beam_to_pixel_top.sv
`timescale 1ns / 100ps

module tb_lidar_beam_to_pixel_top;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 30;
    localparam int SETTLE       = 4;
    localparam int MAX_PRINTED  = 40;
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;
    localparam longint SAMPLE_TOP = (longint'(1) << lbp_pkg::RANGE_W) - 1;
    localparam int ARCTAN [lbp_pkg::CORDIC_STAGES] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    typedef struct packed {
        logic [lbp_pkg::PIX_W-1:0] x;
        logic [lbp_pkg::PIX_W-1:0] y;
        logic                      hit;
    } pixel_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [lbp_pkg::IDX_W-1:0]      beam_index;
    logic [lbp_pkg::RANGE_W-1:0]    range_sample;
    logic                           wr_en;
    logic [lbp_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [lbp_pkg::CFG_DATA_W-1:0] wr_data;
    logic                           done;
    logic [lbp_pkg::PIX_W-1:0]      pixel_x;
    logic [lbp_pkg::PIX_W-1:0]      pixel_y;
    logic                           hit;

    // Copy of the register file as the block should hold it.
    logic [lbp_pkg::ANGLE_W-1:0]    cfg_angle_start;
    logic [lbp_pkg::ANGLE_W-1:0]    cfg_angle_step;
    logic [lbp_pkg::RANGE_W-1:0]    cfg_range_floor;
    logic [lbp_pkg::RANGE_W-1:0]    cfg_range_limit;
    logic [lbp_pkg::SCALE_W-1:0]    cfg_pix_per_m;

    pixel_t pending_pixels[$];
    bit     gaps_on;
    int     cycles;
    int     mismatches;
    int     beams_sent;
    int     results_checked;
    int     hits_seen;
    int     config_phases;

    lidar_beam_to_pixel_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .beam_index   (beam_index),
        .range_sample (range_sample),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .hit          (hit)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic pixel_t project_beam(input logic [lbp_pkg::IDX_W-1:0] idx,
                                            input logic [lbp_pkg::RANGE_W-1:0] rng);
        pixel_t                      res;
        logic [lbp_pkg::ANGLE_W-1:0] ang;
        longint                      rel_range;
        longint                      prod_x;
        longint                      prod_y;
        longint                      off_x;
        longint                      off_y;
        int                          z;
        int                          cx;
        int                          sy;
        int                          dx;
        int                          dy;
        bit                          flip;
        res = '0;
        rel_range = longint'(rng) - lbp_pkg::RANGE_OFFSET;
        if (rel_range <= longint'(cfg_range_floor) || rel_range >= longint'(cfg_range_limit))
            return res;
        // The beam angle wraps at one full turn, i.e. 16 bits.
        ang = cfg_angle_start + idx * cfg_angle_step;
        z = int'($signed(ang));
        flip = 1'b0;
        cx = lbp_pkg::CORDIC_X0;
        sy = 0;
        // Fold the back half-plane onto the front one and negate at the end.
        if (z > QUARTER_TURN)
        begin
            z = z - HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z = z + HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < lbp_pkg::CORDIC_STAGES; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                sy = sy + dy;
                z = z - ARCTAN[i];
            end
            else
            begin
                cx = cx + dx;
                sy = sy - dy;
                z = z + ARCTAN[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            sy = -sy;
        end
        if (cx > lbp_pkg::Q14_ONE)
            cx = lbp_pkg::Q14_ONE;
        else if (cx < -lbp_pkg::Q14_ONE)
            cx = -lbp_pkg::Q14_ONE;
        if (sy > lbp_pkg::Q14_ONE)
            sy = lbp_pkg::Q14_ONE;
        else if (sy < -lbp_pkg::Q14_ONE)
            sy = -lbp_pkg::Q14_ONE;
        prod_x = rel_range * longint'(cx) * longint'(cfg_pix_per_m);
        prod_y = rel_range * longint'(sy) * longint'(cfg_pix_per_m);
        // Truncate toward zero, not toward minus infinity.
        off_x = (prod_x < 0) ? -((-prod_x) >>> 32) : (prod_x >>> 32);
        off_y = (prod_y < 0) ? -((-prod_y) >>> 32) : (prod_y >>> 32);
        off_x = off_x + lbp_pkg::HALF_IMG;
        off_y = off_y + lbp_pkg::HALF_IMG;
        if (off_x >= 0 && off_x < lbp_pkg::IMAGE_DIM && off_y >= 0 && off_y < lbp_pkg::IMAGE_DIM)
        begin
            res.x = off_x[lbp_pkg::PIX_W-1:0];
            res.y = off_y[lbp_pkg::PIX_W-1:0];
            res.hit = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : check_results
        pixel_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("result strobe with no transfer outstanding");
            else
            begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (want.hit)
                    hits_seen++;
                if (hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit got %b want %b",
                                              results_checked, hit, want.hit));
                if (pixel_x !== want.x)
                    report_mismatch($sformatf("result %0d pixel_x got %0d want %0d",
                                              results_checked, pixel_x, want.x));
                if (pixel_y !== want.y)
                    report_mismatch($sformatf("result %0d pixel_y got %0d want %0d",
                                              results_checked, pixel_y, want.y));
            end
        end
    end

    // Start stays high from one transfer to the next unless a gap is taken.
    task automatic send_beam(input logic [lbp_pkg::IDX_W-1:0] idx,
                             input logic [lbp_pkg::RANGE_W-1:0] rng);
        if (gaps_on && $urandom_range(0, 99) < 12)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        start <= 1'b1;
        beam_index <= idx;
        range_sample <= rng;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pixels = {pending_pixels, project_beam(idx, rng)};
        beams_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lbp_pkg::CFG_IDX_W-1:0] index,
                             input logic [lbp_pkg::CFG_DATA_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= index;
        wr_data <= data;
        @(posedge clk);
        case (index)
            lbp_pkg::REG_ANGLE_START: cfg_angle_start = data[lbp_pkg::ANGLE_W-1:0];
            lbp_pkg::REG_ANGLE_STEP:  cfg_angle_step = data[lbp_pkg::ANGLE_W-1:0];
            lbp_pkg::REG_RANGE_FLOOR: cfg_range_floor = data[lbp_pkg::RANGE_W-1:0];
            lbp_pkg::REG_RANGE_LIMIT: cfg_range_limit = data[lbp_pkg::RANGE_W-1:0];
            lbp_pkg::REG_PIX_PER_M:   cfg_pix_per_m = data[lbp_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [lbp_pkg::CFG_DATA_W-1:0] angle_start_v,
                              input logic [lbp_pkg::CFG_DATA_W-1:0] angle_step_v,
                              input logic [lbp_pkg::CFG_DATA_W-1:0] floor_v,
                              input logic [lbp_pkg::CFG_DATA_W-1:0] limit_v,
                              input logic [lbp_pkg::CFG_DATA_W-1:0] scale_v);
        wait_drained();
        write_reg(lbp_pkg::REG_ANGLE_START, angle_start_v);
        write_reg(lbp_pkg::REG_ANGLE_STEP, angle_step_v);
        write_reg(lbp_pkg::REG_RANGE_FLOOR, floor_v);
        write_reg(lbp_pkg::REG_RANGE_LIMIT, limit_v);
        write_reg(lbp_pkg::REG_PIX_PER_M, scale_v);
        wr_en <= 1'b0;
        config_phases++;
    endtask

    // A limit picked at random, with a scale that puts the range window
    // roughly at the image border, so that hits and misses both occur.
    task automatic random_config();
        int     limit_v;
        int     floor_v;
        longint scale_v;
        limit_v = $urandom_range(1024, 40000);
        floor_v = $urandom_range(0, limit_v / 4);
        scale_v = (longint'(67108864) / limit_v) * longint'($urandom_range(70, 130)) / 100;
        if (scale_v > 65535)
            scale_v = 65535;
        set_config(lbp_pkg::CFG_DATA_W'($urandom), lbp_pkg::CFG_DATA_W'($urandom),
                   lbp_pkg::CFG_DATA_W'(floor_v), lbp_pkg::CFG_DATA_W'(limit_v),
                   lbp_pkg::CFG_DATA_W'(scale_v));
    endtask

    function automatic logic [lbp_pkg::RANGE_W-1:0] pick_range();
        longint lo;
        longint hi;
        longint val;
        int     roll;
        roll = $urandom_range(0, 99);
        lo = longint'(cfg_range_floor) + 1 + lbp_pkg::RANGE_OFFSET;
        hi = longint'(cfg_range_limit) - 1 + lbp_pkg::RANGE_OFFSET;
        if (hi > SAMPLE_TOP)
            hi = SAMPLE_TOP;
        if (roll < 70 && hi >= lo)
            val = lo + longint'($urandom_range(0, 32'(hi - lo)));
        else if (roll < 85)
            val = ($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 2)) - 1;
        else
            val = longint'($urandom) & SAMPLE_TOP;
        if (val < 0)
            val = 0;
        if (val > SAMPLE_TOP)
            val = SAMPLE_TOP;
        return val[lbp_pkg::RANGE_W-1:0];
    endfunction

    task automatic send_random_beams(input int count);
        for (int n = 0; n < count; n++)
            send_beam(lbp_pkg::IDX_W'($urandom), pick_range());
    endtask

    // Runs on the reset values: both ends of the range window and the range port.
    task automatic test_range_edges();
        send_beam(0, 0);
        send_beam(0, lbp_pkg::RANGE_W'(lbp_pkg::RANGE_OFFSET));
        send_beam(0, lbp_pkg::RANGE_W'(lbp_pkg::RANGE_OFFSET + 1));
        send_beam(0, lbp_pkg::RANGE_W'(lbp_pkg::RANGE_OFFSET + 3583));
        send_beam(0, lbp_pkg::RANGE_W'(lbp_pkg::RANGE_OFFSET + 3584));
        send_beam(4095, lbp_pkg::RANGE_W'(SAMPLE_TOP));
        send_beam(4095, 3000);
        send_beam(90, 3000);
        send_beam(180, 3000);
    endtask

    // Angles on both sides of the quarter-turn fold, and the wrap of the sum.
    task automatic test_angle_folding();
        set_config(lbp_pkg::CFG_DATA_W'(QUARTER_TURN - 1), 1, 0, 3584, 18725);
        send_beam(0, 2304);
        send_beam(1, 2304);
        send_beam(2, 2304);
        set_config(20'h0BFFF, 1, 0, 3584, 18725);
        send_beam(0, 2304);
        send_beam(1, 2304);
        send_beam(2, 2304);
        set_config(20'h07FFF, 1, 0, 3584, 18725);
        send_beam(0, 2304);
        send_beam(1, 2304);
        set_config(20'h08000, 20'h07FFF, 0, 3584, 18725);
        send_beam(4095, 3300);
        set_config(20'h07FFF, 20'h08000, 0, 3584, 18725);
        send_beam(4095, 3300);
    endtask

    task automatic test_scale_extremes();
        // A zero scale sends every accepted beam to the image center.
        set_config(0, 182, 0, 3584, 0);
        send_beam(17, 3000);
        send_beam(4000, 300);
        // Widest window and largest scale: long beams fall far off the image.
        set_config(20'h02000, 20'h01000, 0, lbp_pkg::CFG_DATA_W'(SAMPLE_TOP), 20'h0FFFF);
        send_beam(1, lbp_pkg::RANGE_W'(SAMPLE_TOP));
        send_beam(2, 300);
        send_beam(0, 260);
        // Floor and limit both at the top leave no valid range at all.
        set_config(0, 182, lbp_pkg::CFG_DATA_W'(SAMPLE_TOP), lbp_pkg::CFG_DATA_W'(SAMPLE_TOP),
                   18725);
        send_beam(3, lbp_pkg::RANGE_W'(SAMPLE_TOP));
        // Writes to the unused indices must leave the registers alone.
        wait_drained();
        for (int k = int'(lbp_pkg::REG_PIX_PER_M) + 1; k < (1 << lbp_pkg::CFG_IDX_W); k++)
            write_reg(lbp_pkg::CFG_IDX_W'(k), lbp_pkg::CFG_DATA_W'($urandom));
        wr_en <= 1'b0;
        send_beam(3, lbp_pkg::RANGE_W'(SAMPLE_TOP));
    endtask

    task automatic test_random_configs();
        set_config(0, 182, 0, lbp_pkg::CFG_DATA_W'(SAMPLE_TOP), 256);
        send_random_beams(110);
        set_config(20'hF8000, 20'hF7FFF, 0, 1024, 20'h0FFFF);
        send_random_beams(110);
        for (int phase = 0; phase < 6; phase++)
        begin
            random_config();
            send_random_beams(110);
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        random_config();
        send_random_beams(150);
        gaps_on = 1'b1;
    endtask

    // The sender holds off several times until every transfer has produced its result.
    task automatic test_pause_for_results();
        random_config();
        for (int burst = 0; burst < 4; burst++)
        begin
            send_random_beams(25);
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        beam_index = '0;
        range_sample = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        gaps_on = 1'b1;
        cycles = 0;
        mismatches = 0;
        beams_sent = 0;
        results_checked = 0;
        hits_seen = 0;
        config_phases = 0;
        // Register values after reset.
        cfg_angle_start = 16'd0;
        cfg_angle_step = 16'd182;
        cfg_range_floor = 20'd0;
        cfg_range_limit = 20'd3584;
        cfg_pix_per_m = 16'd18725;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_range_edges();
        test_angle_folding();
        test_scale_extremes();
        test_random_configs();
        test_back_to_back();
        test_pause_for_results();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
        $display("Projected %0d beams over %0d register settings; %0d results checked.",
                 beams_sent, config_phases, results_checked);
        $display("%0d of them landed inside the image, the rest were rejected or clipped.",
                 hits_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
sv/lbp_pkg.sv
sv/lbp_angle.sv
sv/lbp_cordic.sv
sv/lbp_scale.sv
sv/lidar_beam_to_pixel_top.sv
tb/tb_lidar_beam_to_pixel_top.sv
